// ===== design/pcc_pkg.sv =====
// Package for the port-based traffic class counter.
// Holds the header offsets, protocol numbers, register map, result codes and shared types.
// Used by every module in this folder; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

  localparam int BYTE_COUNT_WIDTH_DEF   = 48;
  localparam int PACKET_COUNT_WIDTH_DEF = 32;
  localparam int POSITION_WIDTH_DEF     = 16;

  localparam int FRAME_BYTE_W   = 8;
  localparam int WIRE_LEN_W     = 16;
  localparam int PORT_W         = 16;
  localparam int OUT_BYTE_W     = 48;
  localparam int OUT_PACKET_W   = 32;
  localparam int IN_DATA_W      = FRAME_BYTE_W + WIRE_LEN_W;
  localparam int OUT_DATA_W     = OUT_BYTE_W + OUT_PACKET_W;
  localparam int OUT_USER_W     = 4;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;

  localparam int ETH_HEADER_LEN  = 14;
  localparam int IP_PROTO_OFFSET = 9;
  localparam int TCP_OFFSET_BYTE = 12;
  localparam int TCP_MIN_LEN     = 13;
  localparam int UDP_HEADER_LEN  = 8;
  localparam int DST_PORT_OFFSET = 2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [PORT_W-1:0] SSH_PORT_RESET       = 16'd22;
  localparam logic [PORT_W-1:0] WEB_PLAIN_PORT_RESET  = 16'd80;
  localparam logic [PORT_W-1:0] WEB_SECURE_PORT_RESET = 16'd443;

  typedef enum logic [1:0] {
    REG_SSH_PORT   = 2'd0,
    REG_WEB_PLAIN  = 2'd1,
    REG_WEB_SECURE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_COUNTED   = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_DROPPED   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_SSH     = 2'd1,
    CLS_WEB     = 2'd2
  } class_t;

  typedef struct packed {
    status_t                 status;
    class_t                  traffic_class;
    logic                    tx;
    logic [WIRE_LEN_W-1:0]   wire_len;
  } decision_t;

endpackage

`default_nettype wire

// ===== design/pcc_parser.sv =====
// Frame header parser: tracks the byte position, captures the IPv4 and TCP fields it needs
// and registers one classification decision per frame. Depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcc_parser #(
  parameter int POSITION_WIDTH = pcc_pkg::POSITION_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [pcc_pkg::FRAME_BYTE_W-1:0]  frame_byte,
  input  wire                              last_of_frame,
  input  wire                              travel_direction,
  input  wire [pcc_pkg::WIRE_LEN_W-1:0]    wire_length,
  input  wire [pcc_pkg::PORT_W-1:0]        ssh_port,
  input  wire [pcc_pkg::PORT_W-1:0]        web_plain_port,
  input  wire [pcc_pkg::PORT_W-1:0]        web_secure_port,
  output logic                             dec_valid,
  input  wire                              dec_ready,
  output pcc_pkg::decision_t               dec,
  output logic                             frame_open
);
  import pcc_pkg::*;

  localparam int CW = POSITION_WIDTH + 1;

  logic [POSITION_WIDTH-1:0] pos;
  logic [3:0]                ihl;
  logic [7:0]                proto;
  logic [3:0]                tcpw;
  logic [PORT_W-1:0]         port;

  logic [POSITION_WIDTH-1:0] pos_next;
  logic [3:0]                ihl_next;
  logic [7:0]                proto_next;
  logic [3:0]                tcpw_next;
  logic [PORT_W-1:0]         port_next;
  logic [CW-1:0]             pos_w, tstart, port_hi, port_lo, caplen, tcp_end;
  status_t                   status_next;
  class_t                    class_next;
  logic                      take;

  assign in_ready   = !dec_valid || dec_ready;
  assign take       = in_valid && in_ready;
  assign frame_open = (pos != '0);

  always_comb begin
    pos_w      = CW'(pos);
    pos_next   = (pos == '1) ? pos : pos + POSITION_WIDTH'(1);
    ihl_next   = (pos_w == CW'(ETH_HEADER_LEN)) ? frame_byte[3:0] : ihl;
    tstart     = CW'(ETH_HEADER_LEN) + CW'({ihl_next, 2'b00});
    proto_next = (pos_w == CW'(ETH_HEADER_LEN + IP_PROTO_OFFSET)) ? frame_byte : proto;
    tcpw_next  = (pos_w == tstart + CW'(TCP_OFFSET_BYTE)) ? frame_byte[7:4] : tcpw;
    port_hi    = travel_direction ? tstart : tstart + CW'(DST_PORT_OFFSET);
    port_lo    = port_hi + CW'(1);
    port_next  = (pos_w == port_hi || pos_w == port_lo) ? {port[7:0], frame_byte} : port;
    caplen     = pos_w + CW'(1);
    tcp_end    = tstart + CW'({tcpw_next, 2'b00});

    status_next = ST_COUNTED;
    class_next  = CLS_UNKNOWN;
    if (caplen < CW'(ETH_HEADER_LEN + IP_PROTO_OFFSET + 1) || caplen < tstart) begin
      status_next = ST_TRUNCATED;
    end else if (proto_next == PROTO_TCP) begin
      if (caplen < tstart + CW'(TCP_MIN_LEN) || caplen < tcp_end) begin
        status_next = ST_TRUNCATED;
      end else if (port_next == ssh_port) begin
        class_next = CLS_SSH;
      end else if (port_next == web_plain_port || port_next == web_secure_port) begin
        class_next = CLS_WEB;
      end
    end else if (proto_next == PROTO_UDP) begin
      if (caplen < tstart + CW'(UDP_HEADER_LEN)) begin
        status_next = ST_TRUNCATED;
      end
    end else begin
      status_next = ST_DROPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      ihl       <= '0;
      proto     <= '0;
      tcpw      <= '0;
      port      <= '0;
      dec_valid <= 1'b0;
    end else begin
      if (take) begin
        if (last_of_frame) begin
          pos   <= '0;
          ihl   <= '0;
          proto <= '0;
          tcpw  <= '0;
          port  <= '0;
        end else begin
          pos   <= pos_next;
          ihl   <= ihl_next;
          proto <= proto_next;
          tcpw  <= tcpw_next;
          port  <= port_next;
        end
      end
      if (take && last_of_frame) begin
        dec_valid <= 1'b1;
      end else if (dec_ready) begin
        dec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_of_frame) begin
      dec.status        <= status_next;
      dec.traffic_class <= class_next;
      dec.tx            <= travel_direction;
      dec.wire_len      <= wire_length;
    end
  end

endmodule

`default_nettype wire

// ===== design/pcc_counters.sv =====
// Per-class, per-direction byte and packet counters with the result register.
// Takes registered decisions from pcc_parser; depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcc_counters #(
  parameter int BYTE_COUNT_WIDTH   = pcc_pkg::BYTE_COUNT_WIDTH_DEF,
  parameter int PACKET_COUNT_WIDTH = pcc_pkg::PACKET_COUNT_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              dec_valid,
  output logic                             dec_ready,
  input  wire pcc_pkg::decision_t          dec,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [1:0]                       traffic_class,
  output logic [1:0]                       frame_status,
  output logic [pcc_pkg::OUT_BYTE_W-1:0]   class_byte_total,
  output logic [pcc_pkg::OUT_PACKET_W-1:0] class_packet_total
);
  import pcc_pkg::*;

  logic [BYTE_COUNT_WIDTH-1:0]   byte_cnt [2][3];
  logic [PACKET_COUNT_WIDTH-1:0] pkt_cnt  [2][3];

  logic [BYTE_COUNT_WIDTH-1:0]   byte_sum;
  logic [PACKET_COUNT_WIDTH-1:0] pkt_sum;
  logic                          move;
  logic                          counted;

  assign dec_ready = !out_valid || out_ready;
  assign move      = dec_valid && dec_ready;
  assign counted   = (dec.status == ST_COUNTED);
  assign byte_sum  = byte_cnt[dec.tx][dec.traffic_class] + BYTE_COUNT_WIDTH'(dec.wire_len);
  assign pkt_sum   = pkt_cnt[dec.tx][dec.traffic_class] + PACKET_COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int d = 0; d < 2; d++) begin
        for (int c = 0; c < 3; c++) begin
          byte_cnt[d][c] <= '0;
          pkt_cnt[d][c]  <= '0;
        end
      end
    end else begin
      if (move) begin
        out_valid <= 1'b1;
        if (counted) begin
          byte_cnt[dec.tx][dec.traffic_class] <= byte_sum;
          pkt_cnt[dec.tx][dec.traffic_class]  <= pkt_sum;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      frame_status <= dec.status;
      if (counted) begin
        traffic_class      <= dec.traffic_class;
        class_byte_total   <= OUT_BYTE_W'(byte_sum);
        class_packet_total <= OUT_PACKET_W'(pkt_sum);
      end else begin
        traffic_class      <= CLS_UNKNOWN;
        class_byte_total   <= '0;
        class_packet_total <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/packet_port_class_counter_top.sv =====
// Top level of the port-based traffic class counter: stream ports, register port and assertions.
// Instantiates pcc_parser and pcc_counters; depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one captured frame byte per cycle while s_axis_tready is high, and on the last byte of
// each frame gives one result word with the class, the status and the updated byte and packet
// totals for that class and direction (class unknown and totals zero when the frame was not
// counted). A result passes through the header parser's decision register and then the
// counter bank's read-modify-write into the result register. The input side stalls only when
// both of those registers are full and the output word is not being taken. Port registers must
// be written over the register port while no frame is in flight; the block does not check this.
module packet_port_class_counter_top #(
  parameter int BYTE_COUNT_WIDTH   = pcc_pkg::BYTE_COUNT_WIDTH_DEF,
  parameter int PACKET_COUNT_WIDTH = pcc_pkg::PACKET_COUNT_WIDTH_DEF,
  parameter int POSITION_WIDTH     = pcc_pkg::POSITION_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [pcc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // frame_byte, wire_length
  input  wire                             s_axis_tlast,
  input  wire                             s_axis_tuser,  // travel_direction
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [pcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // class_byte_total, class_packet_total
  output logic [pcc_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // traffic_class, frame_status
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [pcc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire [pcc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pcc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pcc_pkg::*;

  logic [PORT_W-1:0]       ssh_port;
  logic [PORT_W-1:0]       web_plain_port;
  logic [PORT_W-1:0]       web_secure_port;
  cfg_reg_t                reg_sel;

  logic                    dec_valid;
  logic                    dec_ready;
  decision_t               dec;
  logic                    frame_open;
  logic [1:0]              res_class;
  logic [1:0]              res_status;
  logic [OUT_BYTE_W-1:0]   res_bytes;
  logic [OUT_PACKET_W-1:0] res_packets;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ssh_port        <= SSH_PORT_RESET;
      web_plain_port  <= WEB_PLAIN_PORT_RESET;
      web_secure_port <= WEB_SECURE_PORT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_SSH_PORT:   ssh_port        <= pwdata[PORT_W-1:0];
        REG_WEB_PLAIN:  web_plain_port  <= pwdata[PORT_W-1:0];
        REG_WEB_SECURE: web_secure_port <= pwdata[PORT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SSH_PORT:   prdata = CFG_DATA_W'(ssh_port);
      REG_WEB_PLAIN:  prdata = CFG_DATA_W'(web_plain_port);
      REG_WEB_SECURE: prdata = CFG_DATA_W'(web_secure_port);
      default:        prdata = '0;
    endcase
  end

  pcc_parser #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .frame_byte       (s_axis_tdata[FRAME_BYTE_W-1:0]),
    .last_of_frame    (s_axis_tlast),
    .travel_direction (s_axis_tuser),
    .wire_length      (s_axis_tdata[IN_DATA_W-1:FRAME_BYTE_W]),
    .ssh_port         (ssh_port),
    .web_plain_port   (web_plain_port),
    .web_secure_port  (web_secure_port),
    .dec_valid        (dec_valid),
    .dec_ready        (dec_ready),
    .dec              (dec),
    .frame_open       (frame_open)
  );

  pcc_counters #(
    .BYTE_COUNT_WIDTH   (BYTE_COUNT_WIDTH),
    .PACKET_COUNT_WIDTH (PACKET_COUNT_WIDTH)
  ) u_counters (
    .clk                (clk),
    .rst                (rst),
    .dec_valid          (dec_valid),
    .dec_ready          (dec_ready),
    .dec                (dec),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .traffic_class      (res_class),
    .frame_status       (res_status),
    .class_byte_total   (res_bytes),
    .class_packet_total (res_packets)
  );

  assign m_axis_tdata = {res_packets, res_bytes};
  assign m_axis_tuser = {res_status, res_class};

  // A last byte always leaves a decision waiting and the frame state cleared.
  a_last_gives_decision: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> dec_valid && !frame_open)
    else $error("last byte did not produce a decision or clear the frame state");

  // The input only stalls when the output word is held up.
  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // A frame that was not counted carries no class and no totals.
  a_uncounted_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3:2] != ST_COUNTED |->
      m_axis_tuser[1:0] == CLS_UNKNOWN && m_axis_tdata == '0)
    else $error("uncounted result carries a class or totals");

endmodule

`default_nettype wire
